// ===== design/idp_pkg.sv =====
// ----------------------------------------------------------------------------
// idp_pkg
// Shared codes and types for the identifier pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package idp_pkg;

  // request modes
  localparam logic [1:0] MODE_RESERVE    = 2'd0;
  localparam logic [1:0] MODE_DISPOSE    = 2'd1;
  localparam logic [1:0] MODE_REVALIDATE = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_DROPPED   = 2'd2;
  localparam logic [1:0] STATUS_NOT_HELD  = 2'd3;

  // configuration register indexes
  localparam logic REG_RANGE_LOW  = 1'b0;
  localparam logic REG_RANGE_HIGH = 1'b1;

  // reset values of the range registers
  localparam logic [63:0] RANGE_LOW_RESET  = 64'd0;
  localparam logic [63:0] RANGE_HIGH_RESET = 64'd63;

  // width of a queued command kind
  localparam int KIND_W = 3;

  // command kind decided by the front end
  typedef enum logic [KIND_W-1:0] {
    K_RESERVE,
    K_DISPOSE,
    K_KEEP,
    K_REALLOC,
    K_NOT_HELD
  } kind_t;

endpackage

`default_nettype wire

// ===== design/idp_front.sv =====
// ----------------------------------------------------------------------------
// idp_front
// Range registers, span computation and classification of incoming items.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_front import idp_pkg::*; #(
  parameter int POOL_SIZE = 64,
  parameter int OFF_W     = 6,
  parameter int CNT_W     = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [63:0]      cfg_data,
  input  wire logic [1:0]       mode,
  input  wire logic [63:0]      held_ident,
  input  wire logic             still_valid,
  output logic [63:0]           range_low,
  output logic [CNT_W-1:0]      span,
  output kind_t                 cmd_kind,
  output logic [OFF_W-1:0]      cmd_off
);

  logic [63:0] range_high;
  logic [63:0] diff;
  logic [63:0] ident_off;
  logic        in_span;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= RANGE_LOW_RESET;
      range_high <= RANGE_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // span clamped to the pool size, zero for an inverted range
  always_comb begin
    diff = range_high - range_low;
    if (range_high < range_low) begin
      span = '0;
    end else if (diff >= 64'(POOL_SIZE - 1)) begin
      span = CNT_W'(POOL_SIZE);
    end else begin
      span = diff[CNT_W-1:0] + CNT_W'(1);
    end
  end

  // offset of the held identifier and whether it falls inside the span
  assign ident_off = held_ident - range_low;
  assign in_span   = (held_ident >= range_low) && (ident_off < 64'(span));
  assign cmd_off   = ident_off[OFF_W-1:0];

  // classify the item
  always_comb begin
    unique case (mode)
      MODE_RESERVE:    cmd_kind = K_RESERVE;
      MODE_DISPOSE:    cmd_kind = in_span ? K_DISPOSE : K_NOT_HELD;
      MODE_REVALIDATE: cmd_kind = !in_span ? K_NOT_HELD :
                                  (still_valid ? K_KEEP : K_REALLOC);
      default:         cmd_kind = K_NOT_HELD;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/idp_queue.sv =====
// ----------------------------------------------------------------------------
// idp_queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  head_valid,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/idp_back.sv =====
// ----------------------------------------------------------------------------
// idp_back
// Executes queued commands against the held bitmap and drives the result
// register; free offsets come from a fresh pointer, else from a chunked scan.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_back import idp_pkg::*; #(
  parameter int POOL_SIZE = 64,
  parameter int OFF_W     = 6,
  parameter int CNT_W     = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [63:0]      range_low,
  input  wire logic [CNT_W-1:0] span,
  input  wire logic             q_valid,
  input  wire kind_t            q_kind,
  input  wire logic [OFF_W-1:0] q_off,
  input  wire logic [63:0]      q_ident,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            status,
  output logic [63:0]           granted_ident,
  output logic [63:0]           serial
);

  localparam int CHUNK = (POOL_SIZE < 32) ? POOL_SIZE : 32;
  localparam int NCH   = (POOL_SIZE + CHUNK - 1) / CHUNK;
  localparam int CH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int JW    = (CHUNK > 1) ? $clog2(CHUNK) : 1;
  localparam int POS_W = $clog2(NCH * CHUNK + CHUNK + 1);

  typedef enum logic [1:0] {
    S_RUN,
    S_ALLOC,
    S_SEARCH
  } state_t;

  state_t                      state;
  logic [POOL_SIZE-1:0]        held_map;
  logic [CNT_W-1:0]            fresh_offset;
  logic [CNT_W-1:0]            held_count;
  logic [63:0]                 serial_counter;
  logic                        is_reserve;
  logic [CH_W-1:0]             scan_idx;
  logic [POS_W-1:0]            scan_base;

  logic                        out_free;
  logic                        head_held;
  logic                        fresh_ok;
  logic [OFF_W-1:0]            fresh_idx;
  logic [CNT_W-1:0]            lim;
  logic [POS_W-1:0]            lim_ext;
  logic [NCH*CHUNK-1:0]        map_pad;
  logic [NCH-1:0][CHUNK-1:0]   chunks;
  logic [CHUNK-1:0]            chunk_bits;
  logic                        found;
  logic [JW-1:0]               found_j;
  logic [POS_W-1:0]            found_pos;
  logic [OFF_W-1:0]            found_off;
  logic                        scan_last;
  logic [1:0]                  fail_status;

  assign out_free    = !out_valid || out_ready;
  assign head_held   = held_map[q_off];
  assign fresh_ok    = fresh_offset < span;
  assign fresh_idx   = fresh_offset[OFF_W-1:0];
  assign lim         = (held_count < span) ? held_count : span;
  assign lim_ext     = POS_W'(lim);
  assign q_pop       = (state == S_RUN) && q_valid && out_free;
  assign fail_status = is_reserve ? STATUS_EXHAUSTED : STATUS_DROPPED;

  // bitmap padded with held bits up to whole chunks
  always_comb begin
    map_pad = '1;
    map_pad[POOL_SIZE-1:0] = held_map;
  end
  assign chunks     = map_pad;
  assign chunk_bits = chunks[scan_idx];

  // lowest free bit of the current chunk below the limit
  always_comb begin
    found   = 1'b0;
    found_j = '0;
    for (int j = 0; j < CHUNK; j++) begin
      if (!found && !chunk_bits[j] && (scan_base + POS_W'(j) < lim_ext)) begin
        found   = 1'b1;
        found_j = JW'(j);
      end
    end
  end
  assign found_pos = scan_base + POS_W'(found_j);
  assign found_off = found_pos[OFF_W-1:0];
  assign scan_last = (scan_base + POS_W'(CHUNK)) >= lim_ext;

  // sequencer, bitmap and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_RUN;
      out_valid      <= 1'b0;
      held_map       <= '0;
      fresh_offset   <= '0;
      held_count     <= '0;
      serial_counter <= '0;
      is_reserve     <= 1'b0;
      scan_idx       <= '0;
      scan_base      <= '0;
    end else begin
      unique case (state)
        // execute the item at the queue head
        S_RUN: begin
          if (q_valid && out_free) begin
            unique case (q_kind)
              K_RESERVE: begin
                out_valid  <= 1'b0;
                is_reserve <= 1'b1;
                state      <= S_ALLOC;
              end
              K_DISPOSE: begin
                out_valid     <= 1'b1;
                granted_ident <= '0;
                serial        <= '0;
                if (head_held) begin
                  held_map[q_off] <= 1'b0;
                  held_count      <= held_count - CNT_W'(1);
                  if (CNT_W'(q_off) + CNT_W'(1) == fresh_offset) begin
                    fresh_offset <= fresh_offset - CNT_W'(1);
                  end
                  status <= STATUS_OK;
                end else begin
                  status <= STATUS_NOT_HELD;
                end
              end
              K_KEEP: begin
                out_valid     <= 1'b1;
                serial        <= '0;
                status        <= head_held ? STATUS_OK : STATUS_NOT_HELD;
                granted_ident <= head_held ? q_ident : '0;
              end
              K_REALLOC: begin
                if (head_held) begin
                  out_valid       <= 1'b0;
                  held_map[q_off] <= 1'b0;
                  held_count      <= held_count - CNT_W'(1);
                  is_reserve      <= 1'b0;
                  state           <= S_ALLOC;
                end else begin
                  out_valid     <= 1'b1;
                  status        <= STATUS_NOT_HELD;
                  granted_ident <= '0;
                  serial        <= '0;
                end
              end
              default: begin
                out_valid     <= 1'b1;
                status        <= STATUS_NOT_HELD;
                granted_ident <= '0;
                serial        <= '0;
              end
            endcase
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end

        // fresh pointer first, otherwise fail if the scan limit is zero, else start the scan
        S_ALLOC: begin
          if (out_free) begin
            if (fresh_ok) begin
              fresh_offset <= fresh_offset + CNT_W'(1);
              if (!held_map[fresh_idx]) begin
                held_map[fresh_idx] <= 1'b1;
                held_count          <= held_count + CNT_W'(1);
              end
              out_valid     <= 1'b1;
              status        <= STATUS_OK;
              granted_ident <= range_low + 64'(fresh_idx);
              serial        <= is_reserve ? serial_counter : '0;
              if (is_reserve) begin
                serial_counter <= serial_counter + 64'd1;
              end
              state <= S_RUN;
            end else if (lim == '0) begin
              out_valid     <= 1'b1;
              status        <= fail_status;
              granted_ident <= '0;
              serial        <= '0;
              state         <= S_RUN;
            end else begin
              scan_idx  <= '0;
              scan_base <= '0;
              state     <= S_SEARCH;
            end
          end
        end

        // one chunk of the bitmap per cycle while the result register is free
        S_SEARCH: begin
          if (out_free) begin
            if (found) begin
              held_map[found_off] <= 1'b1;
              held_count          <= held_count + CNT_W'(1);
              out_valid           <= 1'b1;
              status              <= STATUS_OK;
              granted_ident       <= range_low + 64'(found_off);
              serial              <= is_reserve ? serial_counter : '0;
              if (is_reserve) begin
                serial_counter <= serial_counter + 64'd1;
              end
              state <= S_RUN;
            end else if (scan_last) begin
              out_valid     <= 1'b1;
              status        <= fail_status;
              granted_ident <= '0;
              serial        <= '0;
              state         <= S_RUN;
            end else begin
              scan_idx  <= scan_idx + CH_W'(1);
              scan_base <= scan_base + POS_W'(CHUNK);
            end
          end
        end

        default: state <= S_RUN;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/identifier_pool_allocator.sv =====
// Dispose, keep and not-held results are registered once the item reaches the
// queue head; reserve and reallocate pass S_ALLOC (fresh pointer) and, once the
// fresh pointer has reached the span, S_SEARCH over min(held, span) entries in
// chunks of up to 32. Dispose, keep and not-held: one item per cycle while the
// result is not stalled; a stalled result or an allocation stalls the back end.
// Reset: synchronous; clears bitmap, pointers, serial counter and queue.
// ----------------------------------------------------------------------------
// identifier_pool_allocator
// Hands out identifiers from a configured range, tracking held entries in a
// bitmap; a front end classifies items into a queue drained by the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module identifier_pool_allocator import idp_pkg::*; #(
  parameter int POOL_SIZE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] held_ident,
  input  wire logic        still_valid,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [63:0]      granted_ident,
  output logic [63:0]      serial
);

  localparam int OFF_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam int Q_W   = KIND_W + OFF_W + 64;

  logic [63:0]      range_low;
  logic [CNT_W-1:0] span;
  kind_t            cmd_kind;
  logic [OFF_W-1:0] cmd_off;
  logic             q_valid;
  logic             q_pop;
  logic [Q_W-1:0]   q_data;
  kind_t            q_kind;
  logic [OFF_W-1:0] q_off;
  logic [63:0]      q_ident;

  // classification
  idp_front #(
    .POOL_SIZE (POOL_SIZE),
    .OFF_W     (OFF_W),
    .CNT_W     (CNT_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .held_ident  (held_ident),
    .still_valid (still_valid),
    .range_low   (range_low),
    .span        (span),
    .cmd_kind    (cmd_kind),
    .cmd_off     (cmd_off)
  );

  // command queue
  idp_queue #(
    .WIDTH (Q_W),
    .DEPTH (2)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  ({cmd_kind, cmd_off, held_ident}),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_data  (q_data)
  );

  assign q_kind  = kind_t'(q_data[Q_W-1 -: KIND_W]);
  assign q_off   = q_data[64 +: OFF_W];
  assign q_ident = q_data[63:0];

  // execution
  idp_back #(
    .POOL_SIZE (POOL_SIZE),
    .OFF_W     (OFF_W),
    .CNT_W     (CNT_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .range_low     (range_low),
    .span          (span),
    .q_valid       (q_valid),
    .q_kind        (q_kind),
    .q_off         (q_off),
    .q_ident       (q_ident),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_ident (granted_ident),
    .serial        (serial)
  );

endmodule

`default_nettype wire

// ===== design/idp_checker.sv =====
// ----------------------------------------------------------------------------
// idp_checker
// Port-level checks on the identifier pool allocator result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module idp_checker import idp_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [63:0] granted_ident,
  input wire logic [63:0] serial
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status)
      && $stable(granted_ident) && $stable(serial))
    else $error("stalled result changed");

  // failed items grant nothing
  a_fail_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> granted_ident == 64'd0)
    else $error("identifier granted on failure");

  // failed items draw no serial
  a_fail_no_serial: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> serial == 64'd0)
    else $error("serial drawn on failure");

endmodule

bind identifier_pool_allocator idp_checker u_idp_checker (.*);

`default_nettype wire
